### design/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types, address codes and helpers for the bank switch mapper with
// scanline interrupt counter.
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

  // Field widths
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned MAP_W    = 21;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned BANK_W   = 8;
  localparam int unsigned IRQ_W    = 16;
  localparam int unsigned PRG_SLOTS = 4;
  localparam int unsigned CHR_SLOTS = 8;

  // Scanline counter step and firing threshold
  localparam logic [IRQ_W-1:0] IRQ_STEP  = IRQ_W'(113);
  localparam logic [IRQ_W-1:0] IRQ_LIMIT = 16'hFFFF - IRQ_STEP;

  // Mapper register addresses
  localparam logic [ADDR_W-1:0] ADDR_MIRROR_SINGLE = 16'h42FE;
  localparam logic [ADDR_W-1:0] ADDR_MIRROR_DUAL   = 16'h42FF;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_DISABLE   = 16'h4501;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_LOW       = 16'h4502;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_HIGH      = 16'h4503;
  localparam logic [ADDR_W-1:0] ADDR_PRG_FIRST     = 16'h4504;
  localparam logic [ADDR_W-1:0] ADDR_PRG_LAST      = 16'h4507;
  localparam logic [ADDR_W-1:0] ADDR_CHR_FIRST     = 16'h4510;
  localparam logic [ADDR_W-1:0] ADDR_CHR_LAST      = 16'h4517;

  // Bit of the write data that selects mirroring
  localparam int unsigned MIRROR_SEL_BIT = 4;

  typedef enum logic [1:0] {
    MODE_REG_WRITE = 2'd0,
    MODE_SCANLINE  = 2'd1,
    MODE_CPU_XLATE = 2'd2,
    MODE_PPU_XLATE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    MIRROR_SINGLE_A   = 2'd0,
    MIRROR_SINGLE_B   = 2'd1,
    MIRROR_VERTICAL   = 2'd2,
    MIRROR_HORIZONTAL = 2'd3
  } mirror_e;

  typedef enum logic {
    CFG_PRG_BANK_COUNT = 1'b0,
    CFG_CHR_BANK_COUNT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    mode_e             mode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic             irq_request;
    logic [1:0]       mirror_mode;
    logic             address_hit;
    logic [MAP_W-1:0] mapped_address;
  } result_t;

  // Largest power of two not above v, capped at 256; zero for zero
  function automatic logic [COUNT_W-1:0] pow2_floor(logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] p;
    p = '0;
    for (int i = 0; i < COUNT_W - 1; i++) begin
      if (v[i]) begin
        p = COUNT_W'(1) << i;
      end
    end
    if (v[COUNT_W-1]) begin
      p = COUNT_W'(256);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### design/bank_switch_mapper_scanline_irq_unit.sv
// ----------------------------------------------------------------------------
// bank_switch_mapper_scanline_irq_unit
// Cartridge bank mapper with program/pattern bank registers, mirroring
// select and a scanline interrupt counter.
// ----------------------------------------------------------------------------
// Timing: an accepted item is held in the input register, then makes one pass
//   through the execute logic into the result register.
// Throughput: one item per cycle while the output is not stalled, set by the
//   single execute stage.
// Reset: banks 0,1,0,1 and 0..7, vertical mirroring, counter idle, bank
//   counts 2 and 0 (pattern RAM); configuration always ready.
`default_nettype none

module bank_switch_mapper_scanline_irq_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire bsm_pkg::item_t              in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output bsm_pkg::result_t                 out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire bsm_pkg::cfg_reg_e           cfg_index_i,
  input  wire logic [bsm_pkg::COUNT_W-1:0] cfg_data_i
);

  logic             fire;
  logic             item_valid;
  bsm_pkg::item_t   item;
  bsm_pkg::result_t result;
  logic             cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  bsm_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .fire_i       (fire),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  bsm_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result)
  );

  bsm_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .result_i     (result),
    .fire_o       (fire),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // Every executed item shows up as a result on the next cycle
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("executed item produced no result");

  // A waiting item is neither dropped nor changed
  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && !fire |=> item_valid && $stable(item))
    else $error("waiting input item lost or changed");

  // No mapped address without a window hit
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.address_hit |-> out_data_o.mapped_address == '0)
    else $error("mapped address nonzero on a miss");

  // Interrupt only comes from a scanline tick
  a_irq_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && result.irq_request |-> item.mode == bsm_pkg::MODE_SCANLINE)
    else $error("interrupt raised outside a scanline tick");

endmodule

`default_nettype wire

### design/bsm_in_reg.sv
// ----------------------------------------------------------------------------
// bsm_in_reg
// Input register: captures one transfer and holds it until the execute
// stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_in_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire bsm_pkg::item_t in_data_i,
  input  wire logic           fire_i,
  output logic                item_valid_o,
  output bsm_pkg::item_t      item_o
);

  logic           valid_q, valid_d;
  bsm_pkg::item_t item_q, item_d;
  logic           load;

  // Load whenever the register is empty or its item moves on this cycle
  assign load       = !valid_q || fire_i;
  assign in_stall_o = !load;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = in_valid_i;
      item_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

### design/bsm_exec.sv
// ----------------------------------------------------------------------------
// bsm_exec
// Mapper state and execute logic: register writes, scanline counter and
// CPU/PPU address translation, one item per cycle while fire_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_exec (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire bsm_pkg::item_t                item_i,
  input  wire logic                          cfg_we_i,
  input  wire bsm_pkg::cfg_reg_e             cfg_index_i,
  input  wire logic [bsm_pkg::COUNT_W-1:0]   cfg_data_i,
  output bsm_pkg::result_t                   result_o
);

  localparam int unsigned B = bsm_pkg::BANK_W;

  logic [B-1:0]            prg_bank_q [bsm_pkg::PRG_SLOTS];
  logic [B-1:0]            prg_bank_d [bsm_pkg::PRG_SLOTS];
  logic [B-1:0]            chr_bank_q [bsm_pkg::CHR_SLOTS];
  logic [B-1:0]            chr_bank_d [bsm_pkg::CHR_SLOTS];
  bsm_pkg::mirror_e        mirror_q, mirror_d;
  logic                    irq_en_q, irq_en_d;
  logic [bsm_pkg::IRQ_W-1:0] irq_cnt_q, irq_cnt_d;
  logic [bsm_pkg::IRQ_W-1:0] irq_rld_q, irq_rld_d;
  logic [B-1:0]            prg_mask_q, prg_mask_d;
  logic [B-1:0]            chr_mask_q, chr_mask_d;
  logic                    chr_ram_q, chr_ram_d;

  logic [bsm_pkg::COUNT_W-1:0] prg_n, chr_n;
  logic [bsm_pkg::ADDR_W-1:0]  addr;
  logic [bsm_pkg::DATA_W-1:0]  wdata;
  logic [B-1:0]                prg_sel, chr_sel;
  logic                        irq_fire;

  assign addr  = item_i.address;
  assign wdata = item_i.write_data;

  // Effective bank counts from configuration data
  always_comb begin
    prg_n = bsm_pkg::pow2_floor(cfg_data_i);
    if (prg_n < bsm_pkg::COUNT_W'(2)) begin
      prg_n = bsm_pkg::COUNT_W'(2);
    end
    chr_n = bsm_pkg::pow2_floor(cfg_data_i);
  end

  // Next state: configuration writes and item side effects
  always_comb begin
    prg_bank_d = prg_bank_q;
    chr_bank_d = chr_bank_q;
    mirror_d   = mirror_q;
    irq_en_d   = irq_en_q;
    irq_cnt_d  = irq_cnt_q;
    irq_rld_d  = irq_rld_q;
    prg_mask_d = prg_mask_q;
    chr_mask_d = chr_mask_q;
    chr_ram_d  = chr_ram_q;
    irq_fire   = 1'b0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        bsm_pkg::CFG_PRG_BANK_COUNT: begin
          prg_mask_d    = B'(prg_n - bsm_pkg::COUNT_W'(1));
          prg_bank_d[0] = B'(0);
          prg_bank_d[1] = B'(1);
          prg_bank_d[2] = B'(prg_n - bsm_pkg::COUNT_W'(2));
          prg_bank_d[3] = B'(prg_n - bsm_pkg::COUNT_W'(1));
        end
        bsm_pkg::CFG_CHR_BANK_COUNT: begin
          chr_ram_d  = (chr_n == '0);
          chr_mask_d = B'(chr_n - bsm_pkg::COUNT_W'(1));
        end
        default: begin
        end
      endcase
    end

    if (fire_i) begin
      case (item_i.mode)
        bsm_pkg::MODE_REG_WRITE: begin
          case (addr) inside
            bsm_pkg::ADDR_MIRROR_SINGLE: begin
              mirror_d = wdata[bsm_pkg::MIRROR_SEL_BIT] ? bsm_pkg::MIRROR_SINGLE_B
                                                         : bsm_pkg::MIRROR_SINGLE_A;
            end
            bsm_pkg::ADDR_MIRROR_DUAL: begin
              mirror_d = wdata[bsm_pkg::MIRROR_SEL_BIT] ? bsm_pkg::MIRROR_HORIZONTAL
                                                         : bsm_pkg::MIRROR_VERTICAL;
            end
            bsm_pkg::ADDR_IRQ_DISABLE: begin
              irq_en_d = 1'b0;
            end
            bsm_pkg::ADDR_IRQ_LOW: begin
              irq_rld_d = {irq_rld_q[15:8], wdata};
            end
            bsm_pkg::ADDR_IRQ_HIGH: begin
              irq_rld_d = {wdata, irq_rld_q[7:0]};
              irq_cnt_d = {wdata, irq_rld_q[7:0]};
              irq_en_d  = 1'b1;
            end
            [bsm_pkg::ADDR_PRG_FIRST:bsm_pkg::ADDR_PRG_LAST]: begin
              prg_bank_d[addr[1:0]] = wdata;
            end
            [bsm_pkg::ADDR_CHR_FIRST:bsm_pkg::ADDR_CHR_LAST]: begin
              chr_bank_d[addr[2:0]] = wdata;
            end
            default: begin
            end
          endcase
        end
        bsm_pkg::MODE_SCANLINE: begin
          // Advance the counter; fire and stop at the threshold
          if (irq_en_q) begin
            if (irq_cnt_q >= bsm_pkg::IRQ_LIMIT) begin
              irq_fire  = 1'b1;
              irq_cnt_d = '0;
              irq_en_d  = 1'b0;
            end else begin
              irq_cnt_d = irq_cnt_q + bsm_pkg::IRQ_STEP;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Bank lookups
  assign prg_sel = prg_bank_q[addr[14:13]] & prg_mask_q;
  assign chr_sel = chr_bank_q[addr[12:10]] & chr_mask_q;

  // Result of this item, showing mirroring after its own update
  always_comb begin
    result_o                = '0;
    result_o.irq_request    = irq_fire;
    result_o.mirror_mode    = mirror_d;
    case (item_i.mode)
      bsm_pkg::MODE_CPU_XLATE: begin
        if (addr[15]) begin
          result_o.address_hit    = 1'b1;
          result_o.mapped_address = bsm_pkg::MAP_W'({prg_sel, addr[12:0]});
        end
      end
      bsm_pkg::MODE_PPU_XLATE: begin
        if (addr[15:13] == 3'b000) begin
          result_o.address_hit = 1'b1;
          if (chr_ram_q) begin
            result_o.mapped_address = bsm_pkg::MAP_W'(addr[12:0]);
          end else begin
            result_o.mapped_address = bsm_pkg::MAP_W'({chr_sel, addr[9:0]});
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_bank_q[0] <= B'(0);
      prg_bank_q[1] <= B'(1);
      prg_bank_q[2] <= B'(0);
      prg_bank_q[3] <= B'(1);
      for (int i = 0; i < bsm_pkg::CHR_SLOTS; i++) begin
        chr_bank_q[i] <= B'(i);
      end
      mirror_q   <= bsm_pkg::MIRROR_VERTICAL;
      irq_en_q   <= 1'b0;
      irq_cnt_q  <= '0;
      irq_rld_q  <= '0;
      prg_mask_q <= B'(1);
      chr_mask_q <= '0;
      chr_ram_q  <= 1'b1;
    end else begin
      prg_bank_q <= prg_bank_d;
      chr_bank_q <= chr_bank_d;
      mirror_q   <= mirror_d;
      irq_en_q   <= irq_en_d;
      irq_cnt_q  <= irq_cnt_d;
      irq_rld_q  <= irq_rld_d;
      prg_mask_q <= prg_mask_d;
      chr_mask_q <= chr_mask_d;
      chr_ram_q  <= chr_ram_d;
    end
  end

endmodule

`default_nettype wire

### design/bsm_out_reg.sv
// ----------------------------------------------------------------------------
// bsm_out_reg
// Result register: holds one result until the consumer takes it and lets
// the execute stage refill it in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             item_valid_i,
  input  wire bsm_pkg::result_t result_i,
  output logic                  fire_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output bsm_pkg::result_t      out_data_o
);

  logic             valid_q, valid_d;
  bsm_pkg::result_t data_q, data_d;

  // Advance when the register is empty or being drained
  assign fire_o = item_valid_i && (!valid_q || !out_stall_i);

  always_comb begin
    valid_d = valid_q && out_stall_i;
    data_d  = data_q;
    if (fire_o) begin
      valid_d = 1'b1;
      data_d  = result_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire
